FILE: rtl/core/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared widths, codes and types of the selective-reject receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int SEQ_W      = 32;
  localparam int TAG_W      = 16;
  localparam int LEN_W      = 11;
  localparam int WS_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int TDATA_W    = 64;
  localparam int IN_TUSER_W = 2;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [1:0] {
    ACT_DELIVER = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_REJECT  = 2'd2,
    ACT_EOF_ACK = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQUENCE = 1'd1;

  localparam logic [WS_W-1:0] WINDOW_SIZE_RESET    = 5'd16;
  localparam seq_t            START_SEQUENCE_RESET = 32'd1;

endpackage

FILE: rtl/core/selective_reject_receiver.sv
// ----------------------------------------------------------------------------
// selective_reject_receiver
// Receiver side of a selective-reject sliding window: delivers in-order
// packets, buffers early ones by slot and issues ACK, reject and EOF ACK.
// ----------------------------------------------------------------------------
// One packet is handled at a time and in_tready is low while it is worked on.
// A dropped packet (bad checksum, or any packet after end of file) is taken
// in ST_IDLE and goes no further; an old packet or end of file is answered
// from ST_DECIDE. A packet ahead of the window needs its slot index and an
// in-order packet the slot of the next expected sequence, both computed by
// a bit-serial remainder unit; an in-order packet then drains each buffered
// slot through the slot check and the registered slot-memory read.
// Any wait of a result on out_tready holds the packet in its current state.
// Each transfer on the result side carries one action; out_tlast marks the
// last action caused by a packet.
module selective_reject_receiver #(
  parameter int WINDOW_DEPTH    = 16,
  parameter int PAYLOAD_LEN_MAX = 2047
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sequence_req [31:0], payload_tag [47:32], payload_length [58:48]
  input  logic [srr_pkg::TDATA_W-1:0]       in_tdata,
  // packet_kind [0], crc_bad [1]
  input  logic [srr_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // action_sequence [31:0], deliver_tag [47:32], deliver_length [58:48]
  output logic [srr_pkg::TDATA_W-1:0]       out_tdata,
  // action [1:0]
  output srr_pkg::action_t                  out_tuser,
  output logic                              out_tlast
);
  import srr_pkg::*;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STORE,
    ST_REJECT,
    ST_MOD_DRAIN,
    ST_CHECK,
    ST_READ
  } state_t;

  state_t                 state_r;
  logic [WS_W-1:0]        window_size_r;
  seq_t                   exp_r;
  logic                   reject_sent_r;
  logic                   finished_r;
  logic [WINDOW_DEPTH-1:0] slot_full_r;
  logic [IDX_W-1:0]       slot_r;

  logic                   pkt_kind_r;
  seq_t                   pkt_seq_r;
  tag_t                   pkt_tag_r;
  len_t                   pkt_len_r;

  logic                   out_valid_r;
  action_t                out_action_r;
  seq_t                   out_seq_r;
  tag_t                   out_tag_r;
  len_t                   out_len_r;
  logic                   out_last_r;

  tag_t                   tag_mem [WINDOW_DEPTH];
  len_t                   len_mem [WINDOW_DEPTH];
  tag_t                   rd_tag_r;
  len_t                   rd_len_r;

  logic [WCNT_W-1:0]      used_w;
  logic [WINDOW_DEPTH-1:0] used_mask;
  logic                   any_full;
  logic                   out_free;
  logic                   is_old;
  logic                   is_next;
  logic                   mod_start;
  seq_t                   mod_dividend;
  logic                   mod_done;
  logic [WCNT_W-1:0]      mod_rem;
  logic [IDX_W-1:0]       mod_idx;
  logic                   mem_we;
  logic                   mem_re;
  logic [IDX_W-1:0]       slot_inc;
  len_t                   in_len_sat;
  logic                   in_fire;

  // Window size 0 acts as 1, sizes beyond the built depth act as the depth.
  always_comb begin
    if (window_size_r == '0) begin
      used_w = WCNT_W'(1);
    end else if (32'(window_size_r) > 32'(WINDOW_DEPTH)) begin
      used_w = WCNT_W'(WINDOW_DEPTH);
    end else begin
      used_w = WCNT_W'(window_size_r);
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      used_mask[i] = (32'(i) < 32'(used_w));
    end
  end

  assign any_full  = |(slot_full_r & used_mask);
  assign out_free  = !out_valid_r || out_tready;
  assign is_old    = pkt_seq_r < exp_r;
  assign is_next   = pkt_seq_r == exp_r;
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  assign in_len_sat = (32'(in_tdata[58:48]) > 32'(PAYLOAD_LEN_MAX)) ?
                      LEN_W'(PAYLOAD_LEN_MAX) : in_tdata[58:48];

  // The remainder of an early packet gives its slot; for an in-order packet
  // the remainder of the next expected sequence starts the drain.
  assign mod_start    = (state_r == ST_DECIDE) && !pkt_kind_r && !is_old &&
                        (!is_next || out_free);
  assign mod_dividend = is_next ? exp_r + 1'b1 : pkt_seq_r;
  assign mod_idx      = IDX_W'(mod_rem);
  // When the sequence wraps to zero the next slot is zero for any window size.
  assign slot_inc     = ((exp_r == '1) || ((WCNT_W'(slot_r) + 1'b1) == used_w)) ? '0 :
                        IDX_W'(WCNT_W'(slot_r) + 1'b1);

  assign mem_we = (state_r == ST_STORE) && mod_done;
  assign mem_re = (state_r == ST_CHECK) && any_full && slot_full_r[slot_r];

  srr_mod #(
    .DIV_W (WCNT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (used_w),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mod_idx] <= pkt_tag_r;
      len_mem[mod_idx] <= pkt_len_r;
    end
    if (mem_re) begin
      rd_tag_r <= tag_mem[slot_r];
      rd_len_r <= len_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_size_r <= WINDOW_SIZE_RESET;
      exp_r         <= START_SEQUENCE_RESET;
      reject_sent_r <= 1'b0;
      finished_r    <= 1'b0;
      slot_full_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_SIZE:    window_size_r <= cfg_wdata[WS_W-1:0];
          REG_START_SEQUENCE: exp_r         <= cfg_wdata[SEQ_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            pkt_kind_r <= in_tuser[0];
            pkt_seq_r  <= in_tdata[31:0];
            pkt_tag_r  <= in_tdata[47:32];
            pkt_len_r  <= in_len_sat;
            if (!finished_r && !in_tuser[1]) begin
              state_r <= ST_DECIDE;
            end
          end
        end

        ST_DECIDE: begin
          if (pkt_kind_r) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_action_r <= ACT_EOF_ACK;
              out_seq_r    <= exp_r + 1'b1;
              out_tag_r    <= '0;
              out_len_r    <= '0;
              out_last_r   <= 1'b1;
              exp_r        <= exp_r + 1'b1;
              finished_r   <= 1'b1;
              state_r      <= ST_IDLE;
            end
          end else if (is_old) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_action_r <= ACT_ACK;
              out_seq_r    <= exp_r;
              out_tag_r    <= '0;
              out_len_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= ST_IDLE;
            end
          end else if (is_next) begin
            if (out_free) begin
              out_valid_r   <= 1'b1;
              out_action_r  <= ACT_DELIVER;
              out_seq_r     <= pkt_seq_r;
              out_tag_r     <= pkt_tag_r;
              out_len_r     <= pkt_len_r;
              out_last_r    <= 1'b0;
              exp_r         <= exp_r + 1'b1;
              reject_sent_r <= 1'b0;
              state_r       <= ST_MOD_DRAIN;
            end
          end else begin
            state_r <= ST_STORE;
          end
        end

        ST_STORE: begin
          if (mod_done) begin
            slot_full_r[mod_idx] <= 1'b1;
            state_r <= reject_sent_r ? ST_IDLE : ST_REJECT;
          end
        end

        ST_REJECT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_action_r  <= ACT_REJECT;
            out_seq_r     <= exp_r;
            out_tag_r     <= '0;
            out_len_r     <= '0;
            out_last_r    <= 1'b1;
            reject_sent_r <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end

        ST_MOD_DRAIN: begin
          if (mod_done) begin
            slot_r  <= mod_idx;
            state_r <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (mem_re) begin
            slot_full_r[slot_r] <= 1'b0;
            state_r <= ST_READ;
          end else if (out_free) begin
            // An empty window ends the drain with an ACK, a hole with a reject.
            out_valid_r  <= 1'b1;
            out_action_r <= any_full ? ACT_REJECT : ACT_ACK;
            out_seq_r    <= exp_r;
            out_tag_r    <= '0;
            out_len_r    <= '0;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end

        ST_READ: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_action_r <= ACT_DELIVER;
            out_seq_r    <= exp_r;
            out_tag_r    <= rd_tag_r;
            out_len_r    <= rd_len_r;
            out_last_r   <= 1'b0;
            exp_r        <= exp_r + 1'b1;
            slot_r       <= slot_inc;
            state_r      <= ST_CHECK;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_len_r, out_tag_r, out_seq_r};
  assign out_tuser  = out_action_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/srr_mod.sv
// ----------------------------------------------------------------------------
// srr_mod
// Bit-serial remainder unit: a 32-bit sequence number modulo the window size,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module srr_mod #(
  parameter int DIV_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  srr_pkg::seq_t           dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic [DIV_W-1:0]        remainder
);
  import srr_pkg::*;

  localparam int CNT_W = $clog2(SEQ_W);

  seq_t               dividend_r;
  logic [DIV_W-1:0]   divisor_r;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_W:0]     shifted;

  // The partial remainder stays below the divisor, so one extra bit is enough
  // for the shifted trial value.
  always_comb begin
    shifted = {rem_r, dividend_r[SEQ_W-1]};
    if (shifted >= {1'b0, divisor_r}) begin
      rem_nxt = DIV_W'(shifted - {1'b0, divisor_r});
    end else begin
      rem_nxt = shifted[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r     <= 1'b1;
        dividend_r <= dividend;
        divisor_r  <= divisor;
        rem_r      <= '0;
        cnt_r      <= CNT_W'(SEQ_W - 1);
      end else if (busy_r) begin
        rem_r      <= rem_nxt;
        dividend_r <= {dividend_r[SEQ_W-2:0], 1'b0};
        cnt_r      <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
